### design/hcd_pkg.sv
// Package for the HTTP chunked body decoder.
// Holds the queue item type, result kind codes, byte constants and the hex classifier.
// No dependencies.
package hcd_pkg;

    localparam int unsigned CHUNK_W     = 32;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // One classified body byte, as it sits in the queue.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       is_lf;
        logic       is_cr;
    } item_t;

    function automatic item_t classify(input logic [7:0] b);
        item_t it;
        it.byte_value = b;
        it.is_lf      = (b == CH_LF);
        it.is_cr      = (b == CH_CR);
        it.hex_ok     = 1'b1;
        it.hex_val    = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            it.hex_val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            it.hex_val = 4'(b - 8'h61 + 8'd10);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            it.hex_val = 4'(b - 8'h41 + 8'd10);
        end else begin
            it.hex_ok = 1'b0;
        end
        return it;
    endfunction

endpackage

### design/hcd_front.sv
// Front end of the chunked body decoder: classifies each input byte and queues it.
// Depends on hcd_pkg.
module hcd_front
    import hcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_value,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);

    item_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push, pop;

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= classify(s_byte_value);
        end
    end

endmodule

### design/hcd_back.sv
// Back end of the chunked body decoder: the phase machine and the result register.
// Depends on hcd_pkg.
module hcd_back
    import hcd_pkg::*;
#(
    parameter int unsigned MAX_HEX_DIGITS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  item_t      q_item,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_out_kind,
    output logic [7:0] m_out_byte
);

    localparam int unsigned DC_W = $clog2(MAX_HEX_DIGITS + 1);

    localparam logic [2:0] PH_SIZE  = 3'd0;
    localparam logic [2:0] PH_EXT   = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_CRLF  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;
    localparam logic [2:0] PH_ERROR = 3'd5;

    logic [2:0]         phase_reg, phase_next;
    logic [CHUNK_W-1:0] rem_reg, rem_next;
    logic [DC_W-1:0]    dc_reg, dc_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [7:0]         byte_reg, byte_next;
    logic               pop, emit, line_end;
    logic [1:0]         emit_kind;
    logic [7:0]         emit_byte;

    assign q_ready    = !m_valid_reg || m_ready;
    assign pop        = q_valid && q_ready;
    assign m_valid    = m_valid_reg;
    assign m_out_kind = kind_reg;
    assign m_out_byte = byte_reg;

    always_comb begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        dc_next    = dc_reg;
        emit       = 1'b0;
        emit_kind  = KIND_BYTE;
        emit_byte  = 8'd0;
        line_end   = 1'b0;
        case (phase_reg)
            PH_SIZE: begin
                if (q_item.hex_ok) begin
                    if (dc_reg >= DC_W'(MAX_HEX_DIGITS)) begin
                        phase_next = PH_ERROR;
                        emit       = 1'b1;
                        emit_kind  = KIND_ERROR;
                    end else begin
                        rem_next = {rem_reg[CHUNK_W-5:0], q_item.hex_val};
                        dc_next  = dc_reg + 1'b1;
                    end
                end else if (dc_reg == '0) begin
                    phase_next = PH_ERROR;
                    emit       = 1'b1;
                    emit_kind  = KIND_ERROR;
                end else begin
                    dc_next    = '0;
                    phase_next = PH_EXT;
                    line_end   = q_item.is_lf;
                end
            end
            PH_EXT: begin
                line_end = q_item.is_lf;
            end
            PH_DATA: begin
                rem_next  = rem_reg - 1'b1;
                emit      = 1'b1;
                emit_kind = KIND_BYTE;
                emit_byte = q_item.byte_value;
                if (rem_reg == CHUNK_W'(1)) begin
                    phase_next = PH_CRLF;
                end
            end
            PH_CRLF: begin
                if (q_item.is_lf) begin
                    phase_next = PH_SIZE;
                end else if (!q_item.is_cr) begin
                    phase_next = PH_ERROR;
                    emit       = 1'b1;
                    emit_kind  = KIND_ERROR;
                end
            end
            PH_DONE: begin
                emit      = 1'b1;
                emit_kind = KIND_DONE;
            end
            default: begin
                phase_next = PH_ERROR;
                emit       = 1'b1;
                emit_kind  = KIND_ERROR;
            end
        endcase
        // An LF that closes a size line either starts the data or ends the body.
        if (line_end) begin
            if (rem_reg == '0) begin
                phase_next = PH_DONE;
                emit       = 1'b1;
                emit_kind  = KIND_DONE;
            end else begin
                phase_next = PH_DATA;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        byte_next    = byte_reg;
        if (pop && emit) begin
            m_valid_next = 1'b1;
            kind_next    = emit_kind;
            byte_next    = emit_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SIZE;
            rem_reg     <= '0;
            dc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                phase_reg <= phase_next;
                rem_reg   <= rem_next;
                dc_reg    <= dc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
    end

endmodule

### design/http_chunked_decoder_top.sv
// Top level of the HTTP chunked body decoder.
// Depends on hcd_pkg, hcd_front and hcd_back.

// The decoder takes one byte of a chunked HTTP body per transfer on the s_ channel and
// gives at most one result per byte on the m_ channel: a payload byte (kind 0), body
// complete (kind 1) or format error (kind 2); out_byte is zero for the last two. Hex size
// digits, chunk extensions, the CRLF after each chunk and size lines produce no result.
// A zero-size chunk ends the body, and from then on every byte yields a complete result;
// after a format fault (no size digit, more than MAX_HEX_DIGITS digits, or a byte other
// than CR or LF after the chunk data) every byte yields an error result, until reset.
// The block sustains one byte per clock cycle while m_ready stays high: the front end
// classifies each byte and writes it into a four-entry queue, and the back end retires
// one queued byte per cycle, unless a held result waits on m_ready, through its phase
// machine into a registered output. When the result side stalls, the queue absorbs up to
// four bytes before s_ready falls.
module http_chunked_decoder_top
    import hcd_pkg::*;
#(
    parameter int unsigned MAX_HEX_DIGITS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_out_kind,
    output logic [7:0] m_out_byte
);

    // Queue between the front and back ends.
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    hcd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_value (s_byte_value),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item)
    );

    hcd_back #(
        .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_kind (m_out_kind),
        .m_out_byte (m_out_byte)
    );

`ifndef SYNTHESIS
    // Only payload results carry a byte.
    a_status_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_kind != KIND_BYTE) |-> m_out_byte == 8'd0)
        else $error("status result carries a nonzero byte");

    // After an error result is transferred, any following result is an error too.
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_out_kind == KIND_ERROR) ##1 m_valid
        |-> m_out_kind == KIND_ERROR)
        else $error("result after an error is not an error");

    // After a complete result is transferred, any following result is complete too.
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_out_kind == KIND_DONE) ##1 m_valid
        |-> m_out_kind == KIND_DONE)
        else $error("result after body complete is not complete");

    // The input side only stalls when the queue holds bytes.
    a_stall_needs_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_valid)
        else $error("input stalled with an empty queue");
`endif

endmodule
